@@ hdl/ldcb_pkg.sv @@
// ---------------------------------------------------------------------------
// ldcb_pkg: shared types and constants of the display command builder
// Request codes, queue entry layout, command bytes and the segment table.
// ---------------------------------------------------------------------------
`default_nettype none

package ldcb_pkg;

  // request operation codes
  typedef enum logic [2:0] {
    OP_NUMBER = 3'd0,
    OP_TIME   = 3'd1,
    OP_DIGIT  = 3'd2,
    OP_RAW    = 3'd3,
    OP_COLON  = 3'd4,
    OP_ENABLE = 3'd5,
    OP_CLEAR  = 3'd6,
    OP_IGNORE = 3'd7
  } op_t;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_BRIGHTNESS = 3'd0,
    REG_UNITS_ADDR = 3'd1,
    REG_TENS_ADDR  = 3'd2,
    REG_HUND_ADDR  = 3'd3,
    REG_THOU_ADDR  = 3'd4
  } cfg_reg_t;

  // byte phases of one position write
  typedef enum logic [1:0] {
    PH_DATA_CMD = 2'd0,
    PH_ADDR     = 2'd1,
    PH_SEGS     = 2'd2,
    PH_CTRL     = 2'd3
  } phase_t;

  typedef struct packed {
    logic [2:0] brightness;
    logic [2:0] units_address;
    logic [2:0] tens_address;
    logic [2:0] hundreds_address;
    logic [2:0] thousands_address;
  } cfg_t;

  // one queued position write (or a lone control byte)
  typedef struct packed {
    logic [2:0] addr;
    logic [7:0] segs;
    logic       ctrl_only;
    logic       disp_en;
    logic       last;
  } q_entry_t;

  localparam int unsigned LDCB_QUEUE_DEPTH = 4;

  localparam logic [7:0]  CMD_DATA    = 8'h44;
  localparam logic [7:0]  CMD_ADDR    = 8'hC0;
  localparam logic [7:0]  CMD_CTRL    = 8'h80;
  localparam logic [7:0]  CTRL_ON     = 8'h08;
  localparam logic [7:0]  COLON_BIT   = 8'h80;
  localparam logic [15:0] DIV10_MUL   = 16'd52429;
  localparam int unsigned DIV10_SHIFT = 19;

  localparam logic [2:0] RST_BRIGHTNESS = 3'd7;
  localparam logic [2:0] RST_UNITS_ADDR = 3'd3;
  localparam logic [2:0] RST_TENS_ADDR  = 3'd2;
  localparam logic [2:0] RST_HUND_ADDR  = 3'd1;
  localparam logic [2:0] RST_THOU_ADDR  = 3'd0;
  localparam logic [7:0] RST_HUND_CODE  = 8'hFF;

  // digit code to segments; codes above ten are blank
  function automatic logic [7:0] seg_lookup(input logic [7:0] code);
    logic [7:0] segs;
    case (code)
      8'd0:    segs = 8'h3F;
      8'd1:    segs = 8'h06;
      8'd2:    segs = 8'h5B;
      8'd3:    segs = 8'h4F;
      8'd4:    segs = 8'h66;
      8'd5:    segs = 8'h6D;
      8'd6:    segs = 8'h7D;
      8'd7:    segs = 8'h07;
      8'd8:    segs = 8'h7F;
      8'd9:    segs = 8'h6F;
      8'd10:   segs = 8'h80;
      default: segs = 8'h00;
    endcase
    return segs;
  endfunction

endpackage

`default_nettype wire

@@ hdl/ldcb_front.sv @@
// ---------------------------------------------------------------------------
// ldcb_front: request decoder
// Accepts requests, splits them into position writes and queues them.
// ---------------------------------------------------------------------------
`default_nettype none

module ldcb_front import ldcb_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [2:0] in_operation,
  input  logic [15:0] in_number,
  input  logic [7:0] in_minutes,
  input  logic [7:0] in_seconds,
  input  logic [2:0] in_position_address,
  input  logic [7:0] in_digit_code,
  input  logic [7:0] in_raw_segments,
  input  logic       in_flag,
  input  cfg_t       cfg,
  output logic       push,
  output q_entry_t   push_entry,
  input  logic       q_full
);

  logic        busy_r, busy_nxt;
  op_t         op_r, op_nxt;
  logic [2:0]  step_r, step_nxt;
  logic [15:0] val_r, val_nxt;
  logic [7:0]  mins_r, mins_nxt;
  logic [2:0]  addr_r, addr_nxt;
  logic [7:0]  code_r, code_nxt;
  logic [7:0]  raw_r, raw_nxt;
  logic        colon_on_r, colon_on_nxt;
  logic        disp_en_r, disp_en_nxt;
  logic [7:0]  hund_code_r, hund_code_nxt;

  logic [31:0] prod;
  logic [12:0] quot;
  logic [15:0] quot16;
  logic [15:0] rem16;
  logic [3:0]  rem;

  logic        is_digit;
  logic        ctrl_only;
  logic        last_step;
  logic [7:0]  dcode;
  logic [2:0]  e_addr;
  logic [7:0]  raw_segs;
  logic        hund_match;
  logic [7:0]  segs;
  logic        last_push;
  logic        accept;

  // divide by ten through the reciprocal, remainder by shift and add
  assign prod   = val_r * DIV10_MUL;
  assign quot   = prod[31:DIV10_SHIFT];
  assign quot16 = {3'b000, quot};
  assign rem16  = val_r - ((quot16 << 3) + (quot16 << 1));
  assign rem    = rem16[3:0];

  always_comb begin
    is_digit  = 1'b1;
    ctrl_only = 1'b0;
    last_step = 1'b0;
    dcode     = {4'b0000, rem};
    e_addr    = cfg.units_address;
    raw_segs  = 8'h00;
    case (op_r)
      OP_NUMBER: begin
        case (step_r)
          3'd0: e_addr = cfg.units_address;
          3'd1: e_addr = cfg.tens_address;
          3'd2: e_addr = cfg.hundreds_address;
          default: begin
            e_addr    = cfg.thousands_address;
            dcode     = val_r[7:0];
            last_step = 1'b1;
          end
        endcase
      end
      OP_TIME: begin
        case (step_r)
          3'd0: e_addr = cfg.units_address;
          3'd1: e_addr = cfg.tens_address;
          3'd2: e_addr = cfg.hundreds_address;
          default: begin
            e_addr    = cfg.thousands_address;
            last_step = 1'b1;
          end
        endcase
      end
      OP_DIGIT: begin
        e_addr    = addr_r;
        dcode     = code_r;
        last_step = 1'b1;
      end
      OP_RAW: begin
        is_digit  = 1'b0;
        e_addr    = addr_r;
        raw_segs  = raw_r;
        last_step = 1'b1;
      end
      OP_COLON: begin
        e_addr    = cfg.hundreds_address;
        dcode     = hund_code_r;
        last_step = 1'b1;
      end
      OP_ENABLE: begin
        is_digit  = 1'b0;
        ctrl_only = 1'b1;
        last_step = 1'b1;
      end
      OP_CLEAR: begin
        case (step_r)
          3'd0: begin
            e_addr = cfg.hundreds_address;
            dcode  = hund_code_r;
          end
          3'd1: begin
            is_digit = 1'b0;
            e_addr   = cfg.thousands_address;
          end
          3'd2: begin
            is_digit = 1'b0;
            e_addr   = cfg.hundreds_address;
          end
          3'd3: begin
            is_digit = 1'b0;
            e_addr   = cfg.tens_address;
          end
          default: begin
            is_digit  = 1'b0;
            e_addr    = cfg.units_address;
            last_step = 1'b1;
          end
        endcase
      end
      default: begin
        is_digit  = 1'b0;
        last_step = 1'b1;
      end
    endcase
  end

  assign hund_match = is_digit && (e_addr == cfg.hundreds_address);
  assign segs = is_digit ?
                (seg_lookup(dcode) | ((hund_match && colon_on_r) ? COLON_BIT : 8'h00)) :
                raw_segs;

  assign push      = busy_r && !q_full;
  assign last_push = push && last_step;
  assign in_ready  = !busy_r || last_push;
  assign accept    = in_valid && in_ready;

  assign push_entry = '{addr: e_addr, segs: segs, ctrl_only: ctrl_only,
                        disp_en: disp_en_r, last: last_step};

  always_comb begin
    busy_nxt      = busy_r;
    op_nxt        = op_r;
    step_nxt      = step_r;
    val_nxt       = val_r;
    mins_nxt      = mins_r;
    addr_nxt      = addr_r;
    code_nxt      = code_r;
    raw_nxt       = raw_r;
    colon_on_nxt  = colon_on_r;
    disp_en_nxt   = disp_en_r;
    hund_code_nxt = hund_code_r;

    // advance through the position writes of the held request
    if (push) begin
      step_nxt = step_r + 3'd1;
      if (op_r == OP_TIME && step_r == 3'd1) begin
        val_nxt = {8'h00, mins_r};
      end else begin
        val_nxt = quot16;
      end
      if (hund_match) begin
        hund_code_nxt = dcode;
      end
      if (last_step) begin
        busy_nxt = 1'b0;
      end
    end

    // take the next request
    if (accept) begin
      op_nxt   = op_t'(in_operation);
      busy_nxt = (op_t'(in_operation) != OP_IGNORE);
      step_nxt = 3'd0;
      val_nxt  = (op_t'(in_operation) == OP_TIME) ? {8'h00, in_seconds} : in_number;
      mins_nxt = in_minutes;
      addr_nxt = in_position_address;
      code_nxt = in_digit_code;
      raw_nxt  = in_raw_segments;
      case (op_t'(in_operation))
        OP_COLON:  colon_on_nxt = in_flag;
        OP_ENABLE: disp_en_nxt  = in_flag;
        OP_CLEAR:  colon_on_nxt = 1'b0;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      colon_on_r  <= 1'b0;
      disp_en_r   <= 1'b1;
      hund_code_r <= RST_HUND_CODE;
    end else begin
      busy_r      <= busy_nxt;
      colon_on_r  <= colon_on_nxt;
      disp_en_r   <= disp_en_nxt;
      hund_code_r <= hund_code_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r   <= op_nxt;
    step_r <= step_nxt;
    val_r  <= val_nxt;
    mins_r <= mins_nxt;
    addr_r <= addr_nxt;
    code_r <= code_nxt;
    raw_r  <= raw_nxt;
  end

endmodule

`default_nettype wire

@@ hdl/ldcb_queue.sv @@
// ---------------------------------------------------------------------------
// ldcb_queue: position write queue
// Small first-in first-out buffer between the decoder and the byte sender.
// ---------------------------------------------------------------------------
`default_nettype none

module ldcb_queue import ldcb_pkg::*; #(
  parameter int unsigned DEPTH = LDCB_QUEUE_DEPTH
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  q_entry_t push_entry,
  output logic     full,
  input  logic     pop,
  output q_entry_t head,
  output logic     not_empty
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

  q_entry_t         mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign full      = (count_r == CNT_W'(DEPTH));
  assign not_empty = (count_r != '0);
  assign head      = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    count_nxt = count_r + CNT_W'(push) - CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

`default_nettype wire

@@ hdl/ldcb_back.sv @@
// ---------------------------------------------------------------------------
// ldcb_back: byte sender
// Expands each queued position write into link bytes behind an output register.
// ---------------------------------------------------------------------------
`default_nettype none

module ldcb_back import ldcb_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       q_valid,
  input  q_entry_t   head,
  output logic       pop,
  input  logic [2:0] brightness,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_tx_byte,
  output logic       out_start_before,
  output logic       out_stop_after,
  output logic       out_last
);

  phase_t     phase_r, phase_nxt;
  phase_t     cur_ph;
  logic       load;
  logic [7:0] byte_val;
  logic       start_val, stop_val, last_val;

  logic       valid_r, valid_nxt;
  logic [7:0] tx_r;
  logic       start_r, stop_r, last_r;

  assign cur_ph = head.ctrl_only ? PH_CTRL : phase_r;
  assign load   = q_valid && (!valid_r || out_ready);
  assign pop    = load && (cur_ph == PH_CTRL);

  always_comb begin
    byte_val  = CMD_DATA;
    start_val = 1'b1;
    stop_val  = 1'b1;
    last_val  = 1'b0;
    phase_nxt = phase_r;
    case (cur_ph)
      PH_DATA_CMD: begin
        if (load) phase_nxt = PH_ADDR;
      end
      PH_ADDR: begin
        byte_val = CMD_ADDR | {5'b00000, head.addr};
        stop_val = 1'b0;
        if (load) phase_nxt = PH_SEGS;
      end
      PH_SEGS: begin
        byte_val  = head.segs;
        start_val = 1'b0;
        if (load) phase_nxt = PH_CTRL;
      end
      PH_CTRL: begin
        byte_val = CMD_CTRL | {5'b00000, brightness} | (head.disp_en ? CTRL_ON : 8'h00);
        last_val = head.last;
        if (load) phase_nxt = PH_DATA_CMD;
      end
      default: begin
        if (load) phase_nxt = PH_ADDR;
      end
    endcase
  end

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_DATA_CMD;
      valid_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      tx_r    <= byte_val;
      start_r <= start_val;
      stop_r  <= stop_val;
      last_r  <= last_val;
    end
  end

  assign out_valid        = valid_r;
  assign out_tx_byte      = tx_r;
  assign out_start_before = start_r;
  assign out_stop_after   = stop_r;
  assign out_last         = last_r;

endmodule

`default_nettype wire

@@ hdl/led_digit_display_command_builder.sv @@
// ---------------------------------------------------------------------------
// led_digit_display_command_builder: seven-segment link command builder
// Turns display requests into marked byte transfers for a four-digit driver.
// ---------------------------------------------------------------------------
// Usage:
//   in_*  : one display request per handshake (number, time, digit, raw
//           segments, colon, enable, clear); operation 7 is taken and dropped.
//   out_* : one link byte per handshake, with start/stop markers and out_last
//           on the final byte of a request.
//   cfg_* : register writes (brightness and the four grid addresses), always
//           ready; write only while the block is idle.
// Path: a request is registered in the decoder, written into the queue and
//   then loaded into the output register, where its first byte is offered.
// Throughput: one byte per cycle while out_ready stays high and the queue
//   holds writes. A request gives 1 byte (enable), 4 (digit, raw, colon),
//   16 (number, time) or 20 (clear). The byte sender sets the rate; the
//   decoder pushes writes whenever the queue has room, running ahead by up to
//   QUEUE_DEPTH writes, so it accepts the next request while bytes drain.
// Reset: rst_n low clears the queue and output register, restores the
//   register defaults, colon off, display on and a blank hundreds code.
// Stall: while out_ready is low the output byte holds; the queue fills and
//   then in_ready drops until the sender moves again.
// ---------------------------------------------------------------------------
`default_nettype none

module led_digit_display_command_builder import ldcb_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = LDCB_QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  // request channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_operation,
  input  logic [15:0] in_number,
  input  logic [7:0]  in_minutes,
  input  logic [7:0]  in_seconds,
  input  logic [2:0]  in_position_address,
  input  logic [7:0]  in_digit_code,
  input  logic [7:0]  in_raw_segments,
  input  logic        in_flag,
  // byte channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_tx_byte,
  output logic        out_start_before,
  output logic        out_stop_after,
  output logic        out_last,
  // register write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [2:0]  cfg_data
);

  cfg_t     cfg_r, cfg_nxt;
  logic     push;
  q_entry_t push_entry;
  logic     q_full;
  logic     pop;
  q_entry_t head;
  logic     q_valid;

  // registers are always writable; unused indexes are dropped
  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_reg_t'(cfg_index))
        REG_BRIGHTNESS: cfg_nxt.brightness        = cfg_data;
        REG_UNITS_ADDR: cfg_nxt.units_address     = cfg_data;
        REG_TENS_ADDR:  cfg_nxt.tens_address      = cfg_data;
        REG_HUND_ADDR:  cfg_nxt.hundreds_address  = cfg_data;
        REG_THOU_ADDR:  cfg_nxt.thousands_address = cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{brightness: RST_BRIGHTNESS, units_address: RST_UNITS_ADDR,
                 tens_address: RST_TENS_ADDR, hundreds_address: RST_HUND_ADDR,
                 thousands_address: RST_THOU_ADDR};
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // decode requests into position writes
  ldcb_front u_front (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_operation        (in_operation),
    .in_number           (in_number),
    .in_minutes          (in_minutes),
    .in_seconds          (in_seconds),
    .in_position_address (in_position_address),
    .in_digit_code       (in_digit_code),
    .in_raw_segments     (in_raw_segments),
    .in_flag             (in_flag),
    .cfg                 (cfg_r),
    .push                (push),
    .push_entry          (push_entry),
    .q_full              (q_full)
  );

  // hold pending position writes so each side stalls on its own
  ldcb_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (pop),
    .head       (head),
    .not_empty  (q_valid)
  );

  // expand each write into link bytes
  ldcb_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_valid          (q_valid),
    .head             (head),
    .pop              (pop),
    .brightness       (cfg_r.brightness),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_tx_byte      (out_tx_byte),
    .out_start_before (out_start_before),
    .out_stop_after   (out_stop_after),
    .out_last         (out_last)
  );

endmodule

`default_nettype wire

@@ hdl/ldcb_checker.sv @@
// ---------------------------------------------------------------------------
// ldcb_checker: port-level checks of the command builder
// Watches the byte channel for framing and handshake slips.
// ---------------------------------------------------------------------------
`default_nettype none

module ldcb_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_tx_byte,
  input logic       out_start_before,
  input logic       out_stop_after,
  input logic       out_last
);

  // a stalled byte holds with all its markers
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_tx_byte) &&
      $stable(out_start_before) && $stable(out_stop_after) && $stable(out_last))
    else $error("stalled byte changed");

  // nothing is offered straight after reset
  assert property (@(posedge clk)
    rst_n && $past(!rst_n) |-> !out_valid)
    else $error("byte offered after reset");

  // a byte without a leading start is the segment byte, which closes the frame
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_start_before |-> out_stop_after && !out_last)
    else $error("segment byte not closed by stop");

  // the final byte of a request is always a display control byte
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |-> out_start_before && out_stop_after && out_tx_byte[7]
      && !out_tx_byte[6])
    else $error("last byte is not a control byte");

endmodule

bind led_digit_display_command_builder ldcb_checker u_ldcb_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_tx_byte      (out_tx_byte),
  .out_start_before (out_start_before),
  .out_stop_after   (out_stop_after),
  .out_last         (out_last)
);

`default_nettype wire

@@ dv/testbench.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench: self-checking bench for the display command builder
// Drives display requests and register writes, predicts the link bytes of
// every accepted request and compares each byte taken from the block.
// ---------------------------------------------------------------------------

module testbench;
  import ldcb_pkg::*;

  localparam int unsigned RANDOM_REQUESTS = 340; // random requests that do work
  localparam int unsigned PHASE_REQUESTS  = 80;  // requests between setting changes
  localparam int unsigned SETTLE_CYCLES   = 8;   // wait after the owed bytes are out
  localparam int unsigned DRAIN_CYCLES    = 16;
  localparam int unsigned WATCHDOG_CYCLES = 2000;

  // one byte on the link with its framing markers
  typedef struct packed {
    logic [7:0] tx_byte;
    logic       start_before;
    logic       stop_after;
    logic       last;
  } link_byte_t;

  // one display request, every field present whatever the operation
  typedef struct {
    op_t        operation;
    logic [15:0] number;
    logic [7:0]  minutes;
    logic [7:0]  seconds;
    logic [2:0]  position_address;
    logic [7:0]  digit_code;
    logic [7:0]  raw_segments;
    logic        flag;
  } request_t;

  // receiver behaviour for one window of cycles
  typedef enum int unsigned {RX_OPEN, RX_LIGHT, RX_PATTERN, RX_SPARSE} rx_mode_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [2:0]  in_operation;
  logic [15:0] in_number;
  logic [7:0]  in_minutes;
  logic [7:0]  in_seconds;
  logic [2:0]  in_position_address;
  logic [7:0]  in_digit_code;
  logic [7:0]  in_raw_segments;
  logic        in_flag;
  logic        out_valid;
  logic        out_ready;
  logic [7:0]  out_tx_byte;
  logic        out_start_before;
  logic        out_stop_after;
  logic        out_last;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [2:0]  cfg_data;

  // segments of codes 0..9 and the lone dot for code 10
  logic [7:0] digit_glyph [0:10] = '{8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D,
                                     8'h7D, 8'h07, 8'h7F, 8'h6F, 8'h80};

  // shadow of the block: register settings and display state
  cfg_t       shadow_cfg;
  logic       colon_lit;
  logic       display_lit;
  logic [7:0] stored_hundreds_code;

  link_byte_t request_bytes[$];  // bytes of the request being predicted
  link_byte_t pending_bytes[$];  // bytes still owed by the block, oldest first

  int unsigned error_count;
  int unsigned burst_left;
  int unsigned quiet_cycles;

  led_digit_display_command_builder dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_operation        (in_operation),
    .in_number           (in_number),
    .in_minutes          (in_minutes),
    .in_seconds          (in_seconds),
    .in_position_address (in_position_address),
    .in_digit_code       (in_digit_code),
    .in_raw_segments     (in_raw_segments),
    .in_flag             (in_flag),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_tx_byte         (out_tx_byte),
    .out_start_before    (out_start_before),
    .out_stop_after      (out_stop_after),
    .out_last            (out_last),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // -------------------------------------------------------------------------
  // Byte prediction
  // -------------------------------------------------------------------------

  function automatic void queue_byte(logic [7:0] value, logic start_mark, logic stop_mark);
    link_byte_t lb;
    lb.tx_byte      = value;
    lb.start_before = start_mark;
    lb.stop_after   = stop_mark;
    lb.last         = 1'b0;
    request_bytes.push_back(lb);
  endfunction

  // display control: brightness always, the on bit only while enabled
  function automatic void queue_control();
    logic [7:0] ctrl;
    ctrl = CMD_CTRL | {5'd0, shadow_cfg.brightness};
    if (display_lit) ctrl = ctrl | CTRL_ON;
    queue_byte(ctrl, 1'b1, 1'b1);
  endfunction

  // data command, address, segments, then control
  function automatic void queue_position(logic [2:0] grid, logic [7:0] segs);
    queue_byte(CMD_DATA, 1'b1, 1'b1);
    queue_byte(CMD_ADDR | {5'd0, grid}, 1'b1, 1'b0);
    queue_byte(segs, 1'b0, 1'b1);
    queue_control();
  endfunction

  // any digit write landing on the hundreds grid updates its code and takes the colon
  function automatic void queue_digit(logic [2:0] grid, logic [7:0] code);
    logic [7:0] segs;
    segs = 8'h00;
    if (code < 8'd11) segs = digit_glyph[code];
    if (grid == shadow_cfg.hundreds_address) begin
      stored_hundreds_code = code;
      if (colon_lit) segs = segs | COLON_BIT;
    end
    queue_position(grid, segs);
  endfunction

  function automatic void predict_request(request_t r);
    link_byte_t tail;
    request_bytes.delete();
    case (r.operation)
      OP_NUMBER: begin
        queue_digit(shadow_cfg.units_address, 8'(r.number % 16'd10));
        queue_digit(shadow_cfg.tens_address, 8'((r.number / 16'd10) % 16'd10));
        queue_digit(shadow_cfg.hundreds_address, 8'((r.number / 16'd100) % 16'd10));
        queue_digit(shadow_cfg.thousands_address, 8'(r.number / 16'd1000));
      end
      OP_TIME: begin
        queue_digit(shadow_cfg.units_address, r.seconds % 8'd10);
        queue_digit(shadow_cfg.tens_address, (r.seconds / 8'd10) % 8'd10);
        queue_digit(shadow_cfg.hundreds_address, r.minutes % 8'd10);
        queue_digit(shadow_cfg.thousands_address, (r.minutes / 8'd10) % 8'd10);
      end
      OP_DIGIT: queue_digit(r.position_address, r.digit_code);
      OP_RAW:   queue_position(r.position_address, r.raw_segments);
      OP_COLON: begin
        colon_lit = r.flag;
        queue_digit(shadow_cfg.hundreds_address, stored_hundreds_code);
      end
      OP_ENABLE: begin
        display_lit = r.flag;
        queue_control();
      end
      OP_CLEAR: begin
        colon_lit = 1'b0;
        queue_digit(shadow_cfg.hundreds_address, stored_hundreds_code);
        queue_position(shadow_cfg.thousands_address, 8'h00);
        queue_position(shadow_cfg.hundreds_address, 8'h00);
        queue_position(shadow_cfg.tens_address, 8'h00);
        queue_position(shadow_cfg.units_address, 8'h00);
      end
      default: ;
    endcase
    if (request_bytes.size() != 0) begin
      tail = request_bytes.pop_back();
      tail.last = 1'b1;
      request_bytes.push_back(tail);
    end
    foreach (request_bytes[i]) pending_bytes.push_back(request_bytes[i]);
  endfunction

  // -------------------------------------------------------------------------
  // Checking: every accepted byte against the oldest one owed
  // -------------------------------------------------------------------------

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %h got %h", $time, name, want, got);
      error_count++;
    end
  endfunction

  always @(posedge clk) begin : byte_monitor
    link_byte_t want;
    if (rst_n && out_valid === 1'b1 && out_ready) begin
      if (pending_bytes.size() == 0) begin
        $display("%0t: byte expected none got %h start %b stop %b last %b", $time,
                 out_tx_byte, out_start_before, out_stop_after, out_last);
        error_count++;
      end else begin
        want = pending_bytes.pop_front();
        check_field("tx_byte", want.tx_byte, out_tx_byte);
        check_field("start_before", {7'd0, want.start_before}, {7'd0, out_start_before});
        check_field("stop_after", {7'd0, want.stop_after}, {7'd0, out_stop_after});
        check_field("last", {7'd0, want.last}, {7'd0, out_last});
      end
    end
  end

  // Count cycles with no transfer on any channel; end the run if it hangs.
  always @(posedge clk) begin
    if ((in_valid && in_ready === 1'b1) || (out_valid === 1'b1 && out_ready) ||
        (cfg_valid && cfg_ready === 1'b1)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= WATCHDOG_CYCLES) begin
      $display("%0t: no transfer for %0d cycles", $time, WATCHDOG_CYCLES);
      $display("testbench NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // -------------------------------------------------------------------------
  // Receiver: stall on a pattern that changes from window to window. Open
  // windows give stretches with no stall at all; sparse windows hold
  // out_ready low between lone ready cycles so the queue fills and in_ready drops.
  // -------------------------------------------------------------------------
  initial begin : receiver_stall
    rx_mode_t    rx_mode;
    int unsigned window;
    int unsigned hold_off;
    logic [7:0]  ready_bits;
    out_ready = 1'b0;
    hold_off  = 0;
    forever begin
      rx_mode    = rx_mode_t'($urandom_range(0, 3));
      window     = $urandom_range(16, 96);
      ready_bits = 8'($urandom()) | 8'h01;
      repeat (window) begin
        @(negedge clk);
        case (rx_mode)
          RX_OPEN:  out_ready <= 1'b1;
          RX_LIGHT: out_ready <= ($urandom_range(0, 3) != 0);
          RX_PATTERN: begin
            out_ready <= ready_bits[0];
            ready_bits = {ready_bits[0], ready_bits[7:1]};
          end
          default: begin
            if (hold_off == 0) begin
              out_ready <= 1'b1;
              hold_off = $urandom_range(1, 12);
            end else begin
              out_ready <= 1'b0;
              hold_off--;
            end
          end
        endcase
      end
    end
  end

  // -------------------------------------------------------------------------
  // Request and register traffic
  // -------------------------------------------------------------------------

  // Send one request. Inputs move at the falling edge; after each burst,
  // drop valid for a random gap so that valid is never lowered and raised
  // within the same step.
  task automatic send_request(input request_t r);
    @(negedge clk);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
      burst_left = $urandom_range(1, 16);
    end
    in_valid            <= 1'b1;
    in_operation        <= r.operation;
    in_number           <= r.number;
    in_minutes          <= r.minutes;
    in_seconds          <= r.seconds;
    in_position_address <= r.position_address;
    in_digit_code       <= r.digit_code;
    in_raw_segments     <= r.raw_segments;
    in_flag             <= r.flag;
    do @(posedge clk); while (in_ready !== 1'b1);
    predict_request(r);
    burst_left--;
  endtask

  // Hold off new requests until every owed byte is out, then let the
  // latency pass in case the last request was one that gives no byte.
  task automatic settle_block();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_bytes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input cfg_reg_t idx, input logic [2:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    case (idx)
      REG_BRIGHTNESS: shadow_cfg.brightness        = value;
      REG_UNITS_ADDR: shadow_cfg.units_address     = value;
      REG_TENS_ADDR:  shadow_cfg.tens_address      = value;
      REG_HUND_ADDR:  shadow_cfg.hundreds_address  = value;
      REG_THOU_ADDR:  shadow_cfg.thousands_address = value;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic apply_settings(input logic [2:0] level, input logic [2:0] units,
                                input logic [2:0] tens, input logic [2:0] hundreds,
                                input logic [2:0] thousands);
    settle_block();
    write_register(REG_BRIGHTNESS, level);
    write_register(REG_UNITS_ADDR, units);
    write_register(REG_TENS_ADDR, tens);
    write_register(REG_HUND_ADDR, hundreds);
    write_register(REG_THOU_ADDR, thousands);
  endtask

  // Random request; every field is filled so all input bits toggle. Skew
  // numbers below 11000 so the thousands code is often a digit or the dot,
  // and aim a quarter of position writes at the hundreds grid.
  function automatic request_t random_request();
    request_t    r;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 20)      r.operation = OP_NUMBER;
    else if (pick < 35) r.operation = OP_TIME;
    else if (pick < 60) r.operation = OP_DIGIT;
    else if (pick < 70) r.operation = OP_RAW;
    else if (pick < 80) r.operation = OP_COLON;
    else if (pick < 88) r.operation = OP_ENABLE;
    else if (pick < 95) r.operation = OP_CLEAR;
    else                r.operation = OP_IGNORE;
    r.number  = ($urandom_range(0, 3) == 0) ? 16'($urandom()) : 16'($urandom_range(0, 10999));
    r.minutes = ($urandom_range(0, 1) == 0) ? 8'($urandom()) : 8'($urandom_range(0, 59));
    r.seconds = ($urandom_range(0, 1) == 0) ? 8'($urandom()) : 8'($urandom_range(0, 59));
    r.position_address = ($urandom_range(0, 3) == 0) ? shadow_cfg.hundreds_address
                                                     : 3'($urandom_range(0, 7));
    r.digit_code   = ($urandom_range(0, 3) == 0) ? 8'($urandom()) : 8'($urandom_range(0, 11));
    r.raw_segments = 8'($urandom());
    r.flag         = 1'($urandom_range(0, 1));
    return r;
  endfunction

  // -------------------------------------------------------------------------
  // Tests
  // -------------------------------------------------------------------------

  // Reset settings: field extremes, every operation and the corner cases.
  task automatic test_directed_requests();
    request_t r;
    // redraw the blank hundreds code left by reset, with the colon lit
    r = random_request(); r.operation = OP_COLON;  r.flag = 1'b1;        send_request(r);
    r = random_request(); r.operation = OP_NUMBER; r.number = 16'd0;     send_request(r);
    // thousands code 65 shows blank
    r = random_request(); r.operation = OP_NUMBER; r.number = 16'hFFFF;  send_request(r);
    // thousands code 10 shows the dot alone
    r = random_request(); r.operation = OP_NUMBER; r.number = 16'd10987; send_request(r);
    r = random_request(); r.operation = OP_NUMBER; r.number = 16'd9999;  send_request(r);
    r = random_request(); r.operation = OP_TIME;
    r.minutes = 8'd0;   r.seconds = 8'd0;   send_request(r);
    r = random_request(); r.operation = OP_TIME;
    r.minutes = 8'd255; r.seconds = 8'd255; send_request(r);
    r = random_request(); r.operation = OP_DIGIT;
    r.position_address = RST_HUND_ADDR; r.digit_code = 8'd10;  send_request(r);
    // grids beyond five go out as they are
    r = random_request(); r.operation = OP_DIGIT;
    r.position_address = 3'd7;          r.digit_code = 8'd255; send_request(r);
    r = random_request(); r.operation = OP_DIGIT;
    r.position_address = 3'd6;          r.digit_code = 8'd9;   send_request(r);
    r = random_request(); r.operation = OP_DIGIT;
    r.position_address = 3'd0;          r.digit_code = 8'd11;  send_request(r);
    r = random_request(); r.operation = OP_RAW;
    r.position_address = 3'd7;          r.raw_segments = 8'hFF; send_request(r);
    // raw write on the hundreds grid leaves its stored code alone
    r = random_request(); r.operation = OP_RAW;
    r.position_address = RST_HUND_ADDR; r.raw_segments = 8'h00; send_request(r);
    r = random_request(); r.operation = OP_COLON;  r.flag = 1'b0;       send_request(r);
    r = random_request(); r.operation = OP_ENABLE; r.flag = 1'b0;       send_request(r);
    r = random_request(); r.operation = OP_NUMBER; r.number = 16'd1234; send_request(r);
    r = random_request(); r.operation = OP_ENABLE; r.flag = 1'b1;       send_request(r);
    // operation seven is taken and dropped
    r = random_request(); r.operation = OP_IGNORE;                      send_request(r);
    r = random_request(); r.operation = OP_COLON;  r.flag = 1'b1;       send_request(r);
    r = random_request(); r.operation = OP_CLEAR;                       send_request(r);
    // the colon comes back with the code kept through the clear
    r = random_request(); r.operation = OP_COLON;  r.flag = 1'b1;       send_request(r);
    r = random_request(); r.operation = OP_CLEAR;                       send_request(r);
  endtask

  // Extreme register settings, including every grid on one address so
  // each position write to a configured grid matches the hundreds grid.
  task automatic test_register_extremes();
    apply_settings(3'd0, 3'd5, 3'd5, 3'd5, 3'd5);
    repeat (12) send_request(random_request());
    apply_settings(3'd7, 3'd0, 3'd5, 3'd4, 3'd1);
    repeat (12) send_request(random_request());
    apply_settings(3'd3, 3'd0, 3'd0, 3'd0, 3'd0);
    repeat (12) send_request(random_request());
  endtask

  // Random requests under random settings, changed once per phase.
  task automatic test_random_traffic();
    request_t    r;
    int unsigned done;
    int unsigned in_phase;
    done     = 0;
    in_phase = PHASE_REQUESTS;
    while (done < RANDOM_REQUESTS) begin
      if (in_phase == PHASE_REQUESTS) begin
        apply_settings(3'($urandom_range(0, 7)), 3'($urandom_range(0, 5)),
                       3'($urandom_range(0, 5)), 3'($urandom_range(0, 5)),
                       3'($urandom_range(0, 5)));
        in_phase = 0;
      end
      r = random_request();
      send_request(r);
      if (r.operation != OP_IGNORE) begin
        done++;
        in_phase++;
      end
    end
  endtask

  initial begin : run_tests
    rst_n               = 1'b0;
    in_valid            = 1'b0;
    in_operation        = OP_NUMBER;
    in_number           = 16'd0;
    in_minutes          = 8'd0;
    in_seconds          = 8'd0;
    in_position_address = 3'd0;
    in_digit_code       = 8'd0;
    in_raw_segments     = 8'd0;
    in_flag             = 1'b0;
    cfg_valid           = 1'b0;
    cfg_index           = REG_BRIGHTNESS;
    cfg_data            = 3'd0;
    error_count         = 0;
    burst_left          = 0;
    quiet_cycles        = 0;
    shadow_cfg.brightness        = RST_BRIGHTNESS;
    shadow_cfg.units_address     = RST_UNITS_ADDR;
    shadow_cfg.tens_address      = RST_TENS_ADDR;
    shadow_cfg.hundreds_address  = RST_HUND_ADDR;
    shadow_cfg.thousands_address = RST_THOU_ADDR;
    colon_lit            = 1'b0;
    display_lit          = 1'b1;
    stored_hundreds_code = RST_HUND_CODE;

    // hold reset, then release it on a falling edge
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed_requests();
    test_register_extremes();
    test_random_traffic();

    // drain: wait for every owed byte, then allow for stray output
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_bytes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
